// ===== hdl/grcr_pkg.sv =====
// Shared types, constants and constant tables of the grid ray-march column renderer.
package grcr_pkg;

    localparam int SCREEN_WIDTH  = 120;
    localparam int SCREEN_HEIGHT = 40;
    localparam int MAP_SIZE      = 16;
    localparam int MAX_STEPS     = 160;

    localparam int FOV_UNITS = 128;
    // floor(col*FOV/W) as (col*COL_MUL) >> 16
    localparam int COL_MUL   = (FOV_UNITS * 65536 + SCREEN_WIDTH - 1) / SCREEN_WIDTH;
    localparam int CELL_SCALE = 655360;
    localparam int MAP_LIMIT  = MAP_SIZE * CELL_SCALE;
    localparam int EDGE_RATIO = 200;

    localparam int MUL_A_W = 18;
    localparam int MUL_B_W = 14;
    localparam int ACC_W   = 34;
    localparam int D2_W    = 26;
    localparam int POS_W   = 26;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SIN,
        ST_COS,
        ST_INIT,
        ST_MARCH,
        ST_D2,
        ST_PICK,
        ST_EDGE,
        ST_CEIL,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        MAC_HOLD,
        MAC_LOAD,
        MAC_ADD,
        MAC_SUB
    } mac_op_t;

    typedef enum logic [3:0] {
        GL_BLANK  = 4'd0,
        GL_FULL   = 4'd1,
        GL_DARK   = 4'd2,
        GL_MEDIUM = 4'd3,
        GL_LIGHT  = 4'd4,
        GL_HASH   = 4'd5,
        GL_X      = 4'd6,
        GL_DOT    = 4'd7,
        GL_DASH   = 4'd8
    } glyph_t;

    typedef logic [16:0] sin_tab_t [0:256];
    typedef logic signed [9:0] ceil_tab_t [0:255];

    // quarter-wave sine, Q16, polynomial evaluated at elaboration
    function automatic sin_tab_t build_sin_tab();
        sin_tab_t tab;
        longint t;
        longint t2;
        longint inner;
        longint poly;
        longint v;
        for (int r = 0; r <= 256; r++)
        begin
            t     = longint'(r) << 8;
            t2    = (t * t) >> 16;
            inner = 64'd42178 - ((64'd4770 * t2) >> 16);
            poly  = 64'd102944 - ((t2 * inner) >> 16);
            v     = (t * poly) >> 16;
            if (v > 65536)
                v = 65536;
            tab[r] = 17'(v);
        end
        return tab;
    endfunction

    // ceiling row per hit distance, truncated toward zero
    // quotient by repeated subtraction on the magnitude
    function automatic ceil_tab_t build_ceil_tab();
        ceil_tab_t tab;
        int num;
        int den;
        int mag;
        int q;
        for (int k = 0; k < 256; k++)
        begin
            if (k == 0 || k > MAX_STEPS)
                tab[k] = '0;
            else
            begin
                num = SCREEN_HEIGHT * k - 20 * SCREEN_HEIGHT;
                den = 2 * k;
                mag = (num < 0) ? -num : num;
                q   = 0;
                while (mag >= den)
                begin
                    mag = mag - den;
                    q   = q + 1;
                end
                tab[k] = 10'((num < 0) ? -q : q);
            end
        end
        return tab;
    endfunction

    localparam sin_tab_t  SIN_TAB  = build_sin_tab();
    localparam ceil_tab_t CEIL_TAB = build_ceil_tab();

endpackage

// ===== hdl/grcr_mac.sv =====
// Shared signed multiply-accumulate unit of the renderer.
module grcr_mac
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  grcr_pkg::mac_op_t                    op,
    input  logic signed [grcr_pkg::MUL_A_W-1:0]  a,
    input  logic signed [grcr_pkg::MUL_B_W-1:0]  b,
    output logic signed [grcr_pkg::ACC_W-1:0]    sum
);
    import grcr_pkg::*;

    logic signed [MUL_A_W+MUL_B_W-1:0] prod;
    logic signed [ACC_W-1:0]           prod_ext;
    logic signed [ACC_W-1:0]           acc_reg;
    logic signed [ACC_W-1:0]           acc_next;

    assign prod     = a * b;
    assign prod_ext = ACC_W'(prod);

    always_comb
    begin
        unique case (op)
            MAC_LOAD: acc_next = prod_ext;
            MAC_ADD:  acc_next = acc_reg + prod_ext;
            MAC_SUB:  acc_next = acc_reg - prod_ext;
            default:  acc_next = acc_reg;
        endcase
    end

    assign sum = acc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else
            acc_reg <= acc_next;
    end

endmodule

// ===== hdl/grid_ray_march_column_renderer.sv =====
// Top level of the grid ray-march column renderer: sequencer, march datapath and row output.
// One input transaction renders one screen column and yields SCREEN_HEIGHT output
// transactions, top row first, the last one marked by m_tlast. For each column the
// sequencer reads the sine and cosine, sets up the ray, marches it, works the cell corners
// only on a wall hit, looks up the ceiling row and then emits the rows in order, holding
// while the sink stalls. The march loop runs one step per cycle, and the single shared
// multiply-accumulate unit computes the corner distances, dot and cross products.
// s_tready is high only while the sequencer is idle; the last row may still sit in the
// output register when the next column is accepted. Map registers are written over the
// cfg port; the user must keep such writes to idle time, the block does not enforce it. cfg_ready is always high.
module grid_ray_march_column_renderer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // player_x[11:0], player_y[23:12], view_angle[33:24],
                                   // screen_column[40:34], zero pad [47:41]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // screen_row[5:0], glyph[9:6], wall_distance[17:10],
                                   // edge_hit[18], zero pad [23:19]
    output logic        m_tlast,   // last_row
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import grcr_pkg::*;

    // map registers, cell (row r, col c) at bit r*16+c of the concatenation
    logic [63:0]  map_reg [0:3];
    logic [255:0] map_bits;

    state_t state_reg, state_next;

    logic [11:0]                px_reg, py_reg;
    logic [9:0]                 ang_reg;
    logic signed [MUL_A_W-1:0]  sx_reg, cy_reg;
    logic signed [POS_W-1:0]    vx_reg, vy_reg;
    logic [7:0]                 k_reg;
    logic [7:0]                 dist_reg;
    logic                       edge_reg;
    logic [3:0]                 cellx_reg, celly_reg;
    logic [D2_W-1:0]            d2_reg [0:3];
    logic [1:0]                 first_reg, second_reg;
    logic [1:0]                 sel_reg;
    logic [2:0]                 ph_reg;
    logic signed [ACC_W-1:0]    dot_reg, crs_reg;
    logic signed [9:0]          ceil_reg;
    logic [5:0]                 row_reg;

    logic        m_tvalid_reg;
    logic [23:0] m_tdata_reg;
    logic        m_tlast_reg;

    // input fields
    logic [11:0] in_px, in_py;
    logic [9:0]  in_view;
    logic [6:0]  in_col;
    logic [23:0] col_prod;
    logic [9:0]  ang_next;

    assign in_px   = s_tdata[11:0];
    assign in_py   = s_tdata[23:12];
    assign in_view = s_tdata[33:24];
    assign in_col  = s_tdata[40:34];

    // column offset floor(col*FOV/W) by reciprocal multiply
    assign col_prod = 24'(in_col) * 24'(COL_MUL);
    assign ang_next = in_view + 10'(FOV_UNITS / 2) - 10'(col_prod[23:16]);

    // sine lookup, one read place; cos taken a quarter turn later
    logic [9:0]                trig_ang;
    logic [7:0]                trig_r;
    logic [8:0]                trig_idx;
    logic [16:0]               trig_mag;
    logic signed [MUL_A_W-1:0] trig_val;

    assign trig_ang = (state_reg == ST_COS) ? ang_reg + 10'd256 : ang_reg;
    assign trig_r   = trig_ang[7:0];
    assign trig_idx = trig_ang[8] ? 9'd256 - 9'(trig_r) : 9'(trig_r);
    assign trig_mag = SIN_TAB[trig_idx];
    assign trig_val = trig_ang[9] ? -$signed(MUL_A_W'(trig_mag))
                                  : $signed(MUL_A_W'(trig_mag));

    // march step test
    logic [15:0] tx_prod, ty_prod;
    logic [3:0]  tx, ty;
    logic        oob, wall_hit, march_done;

    assign map_bits = {map_reg[3], map_reg[2], map_reg[1], map_reg[0]};
    assign tx_prod  = 16'(vx_reg[23:16]) * 16'd205;   // /10 for values below 1024
    assign ty_prod  = 16'(vy_reg[23:16]) * 16'd205;
    assign tx       = tx_prod[14:11];
    assign ty       = ty_prod[14:11];
    assign oob      = vx_reg[POS_W-1] || vy_reg[POS_W-1]
                   || (vx_reg >= POS_W'(MAP_LIMIT)) || (vy_reg >= POS_W'(MAP_LIMIT));
    assign wall_hit = !oob && map_bits[{ty, tx}];
    assign march_done = oob || (!wall_hit && (k_reg == 8'(MAX_STEPS)));

    // corner vector for the corner under work (index bit 1 = dx, bit 0 = dy)
    logic [1:0]                cidx;
    logic [4:0]                cx5, cy5;
    logic signed [MUL_B_W-1:0] cvx, cvy;

    assign cidx = (state_reg == ST_D2) ? sel_reg : (sel_reg[0] ? second_reg : first_reg);
    assign cx5  = 5'(cellx_reg) + 5'(cidx[1]);
    assign cy5  = 5'(celly_reg) + 5'(cidx[0]);
    assign cvx  = $signed({1'b0, cx5, 8'd0}) - $signed({2'b00, px_reg});
    assign cvy  = $signed({1'b0, cy5, 8'd0}) - $signed({2'b00, py_reg});

    // nearest two corners, earlier index wins ties
    logic [1:0] pick_first, pick_second;
    logic       have_second;

    always_comb
    begin
        pick_first  = 2'd0;
        pick_second = 2'd0;
        have_second = 1'b0;
        for (int i = 1; i < 4; i++)
        begin
            if (d2_reg[i] < d2_reg[pick_first])
                pick_first = 2'(i);
        end
        for (int i = 0; i < 4; i++)
        begin
            if (2'(i) != pick_first && (!have_second || d2_reg[i] < d2_reg[pick_second]))
            begin
                pick_second = 2'(i);
                have_second = 1'b1;
            end
        end
    end

    // corner edge test on stored dot and cross
    logic [ACC_W-1:0] crs_abs;
    logic [ACC_W+7:0] crs_scaled;
    logic             dot_pos, edge_now;

    assign crs_abs    = crs_reg[ACC_W-1] ? ACC_W'(-crs_reg) : ACC_W'(crs_reg);
    assign crs_scaled = (ACC_W+8)'(crs_abs) * (ACC_W+8)'(EDGE_RATIO);
    assign dot_pos    = !dot_reg[ACC_W-1] && (dot_reg != '0);
    assign edge_now   = dot_pos && (crs_scaled < (ACC_W+8)'(dot_reg));

    // shared MAC
    mac_op_t                   mac_op;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [ACC_W-1:0]   mac_sum;

    grcr_mac u_mac
    (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (mac_op),
        .a     (mul_a),
        .b     (mul_b),
        .sum   (mac_sum)
    );

    // glyph of the current row
    logic signed [10:0] yy, c_ext, f_ext;
    logic [6:0]         hy;
    logic [11:0]        hy12;
    logic [9:0]         d10;
    glyph_t             glyph;

    assign yy    = $signed({5'd0, row_reg});
    assign c_ext = 11'(ceil_reg);
    assign f_ext = 11'(SCREEN_HEIGHT) - c_ext;
    assign hy    = 7'(SCREEN_HEIGHT) - 7'(row_reg);
    assign hy12  = 12'(hy);
    assign d10   = 10'(dist_reg);

    always_comb
    begin
        if (yy < c_ext)
            glyph = GL_BLANK;
        else if (yy > c_ext && yy <= f_ext)
        begin
            if (edge_reg)
                glyph = GL_BLANK;
            else if (4 * d10 <= 10'(MAX_STEPS))
                glyph = GL_FULL;
            else if (3 * d10 < 10'(MAX_STEPS))
                glyph = GL_DARK;
            else if (2 * d10 < 10'(MAX_STEPS))
                glyph = GL_MEDIUM;
            else if (d10 < 10'(MAX_STEPS))
                glyph = GL_LIGHT;
            else
                glyph = GL_BLANK;
        end
        else
        begin
            // floor band, b = 2*(H-y)/H
            if (8 * hy12 < 12'(SCREEN_HEIGHT))
                glyph = GL_HASH;
            else if (4 * hy12 < 12'(SCREEN_HEIGHT))
                glyph = GL_X;
            else if (8 * hy12 < 12'(3 * SCREEN_HEIGHT))
                glyph = GL_DOT;
            else if (20 * hy12 < 12'(9 * SCREEN_HEIGHT))
                glyph = GL_DASH;
            else
                glyph = GL_BLANK;
        end
    end

    logic out_load;
    assign out_load = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_SIN;
            ST_SIN:   state_next = ST_COS;
            ST_COS:   state_next = ST_INIT;
            ST_INIT:  state_next = ST_MARCH;
            ST_MARCH:
            begin
                if (wall_hit)
                    state_next = ST_D2;
                else if (march_done)
                    state_next = ST_CEIL;
            end
            ST_D2:    if (ph_reg[0] && sel_reg == 2'd3) state_next = ST_PICK;
            ST_PICK:  state_next = ST_EDGE;
            ST_EDGE:  if (ph_reg == 3'd4 && sel_reg[0]) state_next = ST_CEIL;
            ST_CEIL:  state_next = ST_EMIT;
            ST_EMIT:  if (out_load && row_reg == 6'(SCREEN_HEIGHT - 1)) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // MAC control: d2 = vx*vx + vy*vy; dot = sx*vx + cy*vy; cross = sx*vy - cy*vx
    always_comb
    begin
        mac_op = MAC_HOLD;
        mul_a  = sx_reg;
        mul_b  = cvx;
        unique case (state_reg)
            ST_D2:
            begin
                mac_op = ph_reg[0] ? MAC_ADD : MAC_LOAD;
                mul_a  = ph_reg[0] ? MUL_A_W'(cvy) : MUL_A_W'(cvx);
                mul_b  = ph_reg[0] ? cvy : cvx;
            end
            ST_EDGE:
            begin
                unique case (ph_reg)
                    3'd0:    begin mac_op = MAC_LOAD; mul_a = sx_reg; mul_b = cvx; end
                    3'd1:    begin mac_op = MAC_ADD;  mul_a = cy_reg; mul_b = cvy; end
                    3'd2:    begin mac_op = MAC_LOAD; mul_a = sx_reg; mul_b = cvy; end
                    3'd3:    begin mac_op = MAC_SUB;  mul_a = cy_reg; mul_b = cvx; end
                    default: mac_op = MAC_HOLD;
                endcase
            end
            default: mac_op = MAC_HOLD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                map_reg[i] <= '0;
        end
        else if (cfg_valid)
        begin
            map_reg[cfg_index] <= cfg_data;
        end
    end

    // datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg  <= '0;
            ph_reg   <= '0;
            k_reg    <= '0;
            row_reg  <= '0;
            edge_reg <= 1'b0;
            dist_reg <= 8'(MAX_STEPS);
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        px_reg  <= in_px;
                        py_reg  <= in_py;
                        ang_reg <= ang_next;
                    end
                end
                ST_SIN: sx_reg <= trig_val;
                ST_COS: cy_reg <= trig_val;
                ST_INIT:
                begin
                    vx_reg   <= POS_W'({px_reg, 11'd0}) + POS_W'({px_reg, 9'd0}) + POS_W'(sx_reg);
                    vy_reg   <= POS_W'({py_reg, 11'd0}) + POS_W'({py_reg, 9'd0}) + POS_W'(cy_reg);
                    k_reg    <= 8'd1;
                    edge_reg <= 1'b0;
                end
                ST_MARCH:
                begin
                    if (wall_hit)
                    begin
                        dist_reg  <= k_reg;
                        cellx_reg <= tx;
                        celly_reg <= ty;
                        sel_reg   <= '0;
                        ph_reg    <= '0;
                    end
                    else if (march_done)
                        dist_reg <= 8'(MAX_STEPS);
                    else
                    begin
                        vx_reg <= vx_reg + POS_W'(sx_reg);
                        vy_reg <= vy_reg + POS_W'(cy_reg);
                        k_reg  <= k_reg + 8'd1;
                    end
                end
                ST_D2:
                begin
                    if (ph_reg[0])
                    begin
                        d2_reg[sel_reg] <= D2_W'(mac_sum);
                        sel_reg         <= sel_reg + 2'd1;
                        ph_reg          <= '0;
                    end
                    else
                        ph_reg <= 3'd1;
                end
                ST_PICK:
                begin
                    first_reg  <= pick_first;
                    second_reg <= pick_second;
                    sel_reg    <= '0;
                    ph_reg     <= '0;
                end
                ST_EDGE:
                begin
                    if (ph_reg == 3'd1)
                        dot_reg <= mac_sum;
                    if (ph_reg == 3'd3)
                        crs_reg <= mac_sum;
                    if (ph_reg == 3'd4)
                    begin
                        edge_reg <= edge_reg | edge_now;
                        sel_reg  <= 2'd1;
                        ph_reg   <= '0;
                    end
                    else
                        ph_reg <= ph_reg + 3'd1;
                end
                ST_CEIL:
                begin
                    ceil_reg <= CEIL_TAB[dist_reg];
                    row_reg  <= '0;
                end
                ST_EMIT:
                begin
                    if (out_load)
                        row_reg <= row_reg + 6'd1;
                end
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (out_load)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata_reg <= {5'd0, edge_reg, dist_reg, 4'(glyph), row_reg};
            m_tlast_reg <= (row_reg == 6'(SCREEN_HEIGHT - 1));
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tlast   = m_tlast_reg;
    assign cfg_ready = 1'b1;

`ifndef SYNTHESIS
    a_march_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MARCH |-> (k_reg >= 8'd1 && k_reg <= 8'(MAX_STEPS)))
        else $error("march step out of range");

    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> (dist_reg >= 8'd1 && dist_reg <= 8'(MAX_STEPS)))
        else $error("wall distance out of range");

    a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tdata[5:0] == 6'(SCREEN_HEIGHT - 1))))
        else $error("tlast does not match final row");

    a_edge_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && edge_reg) |-> (dist_reg < 8'(MAX_STEPS) || k_reg == 8'(MAX_STEPS)))
        else $error("edge flagged without a wall hit");
`endif

endmodule

// ===== sim/testbench.sv =====
// Testbench for the grid ray-march column renderer: directed and random columns, self-checking.
`timescale 1ns / 100ps

module testbench;
    import grcr_pkg::*;

    typedef struct packed {
        logic       last_row;
        logic       edge_hit;
        logic [7:0] wall_distance;
        logic [3:0] glyph;
        logic [5:0] screen_row;
    } row_glyph_t;

    localparam longint CYCLE_LIMIT = 3000000;

    // map register indexes
    localparam logic [1:0] REG_ROWS_0_3   = 2'd0;
    localparam logic [1:0] REG_ROWS_4_7   = 2'd1;
    localparam logic [1:0] REG_ROWS_8_11  = 2'd2;
    localparam logic [1:0] REG_ROWS_12_15 = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;     // player_x, player_y, view_angle, screen_column, pad
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;     // screen_row, glyph, wall_distance, edge_hit, pad
    logic        m_tlast;     // last_row
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    // predictor copy of the wall bitmap
    logic [63:0] wall_map [0:3];

    row_glyph_t  expected_rows [$];
    int          mismatch_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          recv_hold_cycles;
    longint      cycle_count;

    grid_ray_march_column_renderer i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // run watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    function automatic longint quarter_wave(int r);
        longint t;
        longint t2;
        longint v;
        t  = longint'(r) << 8;
        t2 = (t * t) >>> 16;
        v  = (t * (102944 - ((t2 * (42178 - ((4770 * t2) >>> 16))) >>> 16))) >>> 16;
        if (v > 65536)
            v = 65536;
        return v;
    endfunction

    function automatic longint sine_units(logic [9:0] a);
        int r;
        r = int'(a[7:0]);
        case (a[9:8])
            2'd0:    return quarter_wave(r);
            2'd1:    return quarter_wave(256 - r);
            2'd2:    return -quarter_wave(r);
            default: return -quarter_wave(256 - r);
        endcase
    endfunction

    function automatic logic cell_is_wall(int cx, int cy);
        return wall_map[cy / 4][(cy % 4) * 16 + cx];
    endfunction

    // true when one of the two nearest corners of the hit cell lies on the ray
    function automatic logic corner_on_ray(longint sx, longint cy, longint px, longint py,
                                           longint cellx, longint celly);
        longint d2 [4];
        longint dp [4];
        longint cr [4];
        longint vx;
        longint vy;
        longint c;
        int     first;
        int     second;
        int     j;
        logic   on_ray;
        first  = 0;
        second = -1;
        on_ray = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            vx    = (cellx + (i >> 1)) * 256 - px;
            vy    = (celly + (i & 1)) * 256 - py;
            d2[i] = vx * vx + vy * vy;
            dp[i] = sx * vx + cy * vy;
            cr[i] = sx * vy - cy * vx;
        end
        for (int i = 1; i < 4; i++)
            if (d2[i] < d2[first])
                first = i;
        for (int i = 0; i < 4; i++)
            if (i != first && (second < 0 || d2[i] < d2[second]))
                second = i;
        for (int i = 0; i < 2; i++)
        begin
            j = (i == 0) ? first : second;
            c = (cr[j] < 0) ? -cr[j] : cr[j];
            if (dp[j] > 0 && c * EDGE_RATIO < dp[j])
                on_ray = 1'b1;
        end
        return on_ray;
    endfunction

    // march one column and queue its SCREEN_HEIGHT rows
    task automatic predict_column(logic [11:0] pos_x, logic [11:0] pos_y,
                                  logic [9:0] view, logic [6:0] column);
        logic [9:0] ang;
        longint     sx;
        longint     cy;
        longint     px;
        longint     py;
        longint     vx;
        longint     vy;
        longint     tx;
        longint     ty;
        longint     hit_dist;
        longint     ceil_row;
        longint     floor_row;
        longint     h;
        longint     b;
        logic       edge_seen;
        row_glyph_t row;
        glyph_t     g;
        px        = longint'(pos_x);
        py        = longint'(pos_y);
        h         = SCREEN_HEIGHT;
        ang       = 10'(int'(view) + 1024 + FOV_UNITS / 2
                        - (int'(column) * FOV_UNITS) / SCREEN_WIDTH);
        sx        = sine_units(ang);
        cy        = sine_units(ang + 10'd256);
        hit_dist  = MAX_STEPS;
        edge_seen = 1'b0;
        for (longint k = 1; k <= MAX_STEPS; k++)
        begin
            vx = px * 2560 + sx * k;
            vy = py * 2560 + cy * k;
            if (vx < 0 || vy < 0)
                break;
            tx = vx / CELL_SCALE;
            ty = vy / CELL_SCALE;
            if (tx >= MAP_SIZE || ty >= MAP_SIZE)
                break;
            if (cell_is_wall(int'(tx), int'(ty)))
            begin
                hit_dist  = k;
                edge_seen = corner_on_ray(sx, cy, px, py, tx, ty);
                break;
            end
        end
        ceil_row  = (h * hit_dist - 20 * h) / (2 * hit_dist);
        floor_row = h - ceil_row;
        for (int y = 0; y < SCREEN_HEIGHT; y++)
        begin
            if (y < ceil_row)
                g = GL_BLANK;
            else if (y > ceil_row && y <= floor_row)
            begin
                if (edge_seen)                      g = GL_BLANK;
                else if (4 * hit_dist <= MAX_STEPS) g = GL_FULL;
                else if (3 * hit_dist < MAX_STEPS)  g = GL_DARK;
                else if (2 * hit_dist < MAX_STEPS)  g = GL_MEDIUM;
                else if (hit_dist < MAX_STEPS)      g = GL_LIGHT;
                else                                g = GL_BLANK;
            end
            else
            begin
                // floor band by row
                b = 2 * h - 2 * y;
                if (4 * b < h)           g = GL_HASH;
                else if (2 * b < h)      g = GL_X;
                else if (4 * b < 3 * h)  g = GL_DOT;
                else if (10 * b < 9 * h) g = GL_DASH;
                else                     g = GL_BLANK;
            end
            row.screen_row    = 6'(y);
            row.glyph         = g;
            row.wall_distance = 8'(hit_dist);
            row.edge_hit      = edge_seen;
            row.last_row      = (y == SCREEN_HEIGHT - 1);
            expected_rows     = {expected_rows, row};
        end
    endtask

    // one column request; predicted at acceptance. Valid stays high after the
    // transaction until the next request or a drain point takes it down.
    task automatic send_column(logic [11:0] pos_x, logic [11:0] pos_y,
                               logic [9:0] view, logic [6:0] column);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, column, view, pos_y, pos_x};
        do
            @(posedge clk);
        while (!s_tready);
        predict_column(pos_x, pos_y, view, column);
    endtask

    // valid stays high after the transaction; load_map takes it down
    task automatic write_map(logic [1:0] index, logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        wall_map[index] = value;
    endtask

    // idle point: rows drained plus the compute latency for safety
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_rows.size() != 0)
            @(posedge clk);
        repeat (300)
            @(posedge clk);
    endtask

    task automatic load_map(logic [63:0] r0, logic [63:0] r1,
                            logic [63:0] r2, logic [63:0] r3);
        wait_drained();
        write_map(REG_ROWS_0_3, r0);
        write_map(REG_ROWS_4_7, r1);
        write_map(REG_ROWS_8_11, r2);
        write_map(REG_ROWS_12_15, r3);
        cfg_valid <= 1'b0;
    endtask

    // border walls only
    task automatic load_box_map();
        load_map(64'h8001_8001_8001_FFFF, 64'h8001_8001_8001_8001,
                 64'h8001_8001_8001_8001, 64'hFFFF_8001_8001_8001);
    endtask

    task automatic test_empty_map();
        // rays leave the map: distance saturates
        send_column(12'd0, 12'd0, 10'd0, 7'd0);
        send_column(12'hFFF, 12'hFFF, 10'h3FF, 7'd119);
        send_column(12'h800, 12'h800, 10'd512, 7'd60);
        send_column(12'h100, 12'hF00, 10'd768, 7'd127);
    endtask

    task automatic test_box_map();
        logic [9:0] views [8];
        views = '{10'd0, 10'd128, 10'd256, 10'd384, 10'd512, 10'd640, 10'd768, 10'd896};
        load_box_map();
        foreach (views[i])
            send_column(12'h880, 12'h780, views[i], 7'(i * 17));
        // close to a wall for tall columns, and player on a corner
        send_column(12'h1F0, 12'h800, 10'd768, 7'd60);
        send_column(12'h200, 12'h200, 10'd640, 7'd60);
        // diagonal toward a corner for edge hits
        send_column(12'h780, 12'h780, 10'd128, 7'd60);
        send_column(12'h780, 12'h780, 10'd384, 7'd60);
        send_column(12'h780, 12'h780, 10'd640, 7'd60);
        send_column(12'h780, 12'h780, 10'd896, 7'd60);
    endtask

    task automatic test_full_map();
        // player inside a wall everywhere: first step hits
        load_map('1, '1, '1, '1);
        send_column(12'h555, 12'hAAA, 10'h155, 7'h2A);
        send_column(12'hAAA, 12'h555, 10'h2AA, 7'h55);
    endtask

    task automatic random_columns(int count);
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        for (int i = 0; i < count; i++)
        begin
            pos_x = 12'($urandom);
            pos_y = 12'($urandom);
            send_column(pos_x, pos_y, 10'($urandom), 7'($urandom_range(127)));
        end
    endtask

    task automatic random_map();
        load_map({$urandom, $urandom} & {$urandom, $urandom},
                 {$urandom, $urandom} & {$urandom, $urandom},
                 {$urandom, $urandom} & {$urandom, $urandom},
                 {$urandom, $urandom} & {$urandom, $urandom});
    endtask

    task automatic test_random();
        send_idle_pct = 31;
        recv_idle_pct = 79;
        load_box_map();
        random_columns(40);
        random_map();
        random_columns(30);
        send_idle_pct = 79;
        recv_idle_pct = 31;
        random_map();
        random_columns(50);
        // long receiver hold-off while requests keep coming
        recv_hold_cycles = 2000;
        random_columns(10);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_map();
        random_columns(40);
        load_box_map();
        random_columns(30);
    endtask

    // result sink: handshake and compare
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (recv_hold_cycles > 0)
            begin
                recv_hold_cycles <= recv_hold_cycles - 1;
                m_tready         <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
        if (m_tvalid && m_tready)
        begin
            if (expected_rows.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected row transaction: %h last %b", m_tdata, m_tlast);
            end
            else
            begin
                row_glyph_t exp_row;
                exp_row = expected_rows.pop_front();
                if (m_tdata[5:0] !== exp_row.screen_row
                    || m_tdata[9:6] !== exp_row.glyph
                    || m_tdata[17:10] !== exp_row.wall_distance
                    || m_tdata[18] !== exp_row.edge_hit
                    || m_tlast !== exp_row.last_row)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("row mismatch: exp row %0d glyph %0d dist %0d edge %b last %b, got row %0d glyph %0d dist %0d edge %b last %b",
                                 exp_row.screen_row, exp_row.glyph, exp_row.wall_distance,
                                 exp_row.edge_hit, exp_row.last_row, m_tdata[5:0],
                                 m_tdata[9:6], m_tdata[17:10], m_tdata[18], m_tlast);
                end
            end
        end
    end

    initial
    begin
        mismatch_count   = 0;
        send_idle_pct    = 31;
        recv_idle_pct    = 79;
        recv_hold_cycles = 0;
        rst_n            = 1'b0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        m_tready         = 1'b0;
        cfg_valid        = 1'b0;
        cfg_index        = REG_ROWS_0_3;
        cfg_data         = '0;
        for (int i = 0; i < 4; i++)
            wall_map[i] = '0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_map();
        test_box_map();
        test_full_map();
        test_random();

        wait_drained();
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
